/* hw/rtl/debounced_edge_counter_macros.svh */
// assertion helpers for the debounced edge counter
`ifndef DEBOUNCED_EDGE_COUNTER_MACROS_SVH
`define DEBOUNCED_EDGE_COUNTER_MACROS_SVH

// same-cycle implication, checked out of reset
`define DEC_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked out of reset
`define DEC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hw/rtl/dec_pkg.sv */
package dec_pkg;

  localparam int unsigned TimeW  = 32;
  localparam int unsigned HoldW  = 16;
  localparam int unsigned DivW   = 16;
  localparam int unsigned CountW = 32;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 16;
  localparam int unsigned InDataW  = 40;
  localparam int unsigned OutDataW = 216;

  typedef enum logic [1:0] {
    OP_SAMPLE = 2'd0,
    OP_ACK    = 2'd1,
    OP_CLEAR  = 2'd2,
    OP_NOP    = 2'd3
  } opcode_t;

  // edge codes, also used for the divided edge kind selection
  localparam logic [1:0] EDGE_NONE = 2'd0;  // as a kind selection: any change
  localparam logic [1:0] EDGE_RISE = 2'd1;
  localparam logic [1:0] EDGE_FALL = 2'd2;
  localparam logic [1:0] EDGE_ANY2 = 2'd3;  // kind selection alias for any change

  localparam logic [CfgIdxW-1:0] CFG_DEBOUNCE_EN = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_RISE_HOLD   = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_FALL_HOLD   = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_DIVIDE_BY   = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_EDGE_KIND   = 3'd4;

  localparam logic [HoldW-1:0] HOLD_RESET   = 16'd25;
  localparam logic [DivW-1:0]  DIVIDE_RESET = 16'd1;
  localparam logic [DivW-1:0]  DIV_MAX      = 16'hFFFF;

  // last member sits in the lowest bits
  typedef struct packed {
    logic [TimeW-1:0]  off_duration;
    logic [TimeW-1:0]  on_duration;
    logic [TimeW-1:0]  change_stamp;
    logic [TimeW-1:0]  fall_stamp;
    logic [TimeW-1:0]  rise_stamp;
    logic              triggered;
    logic [DivW-1:0]   divided_count;
    logic [CountW-1:0] change_count;
    logic [1:0]        edge_kind;
    logic              changed;
    logic              stable_level;
  } result_t;

endpackage

/* hw/rtl/debounced_edge_counter.sv */
// Debounced edge counter. Each input item is a command (tuser) plus a raw pin level
// and a millisecond time stamp (tdata). A sample command commits a new stable level,
// either at once (debounce off) or once the raw level has held strictly longer than
// the rise or fall hold time picked by the pending edge direction (debounce on).
// Committed changes are counted, time stamped and, when they match the selected edge
// kind, counted into a saturating divided count that raises the trigger flag once it
// reaches divide_by (zero acts as one). Acknowledge clears a raised divided count;
// clear zeroes the level and both counts. Every item gives exactly one result item
// with the level, change flag, edge, counts, trigger, stamps and on/off duration;
// time differences wrap modulo 2^32. The block takes one item per clock: all state is
// updated in the cycle an item is accepted and the result lands in a single output
// register, so in_tready stays high unless a result is waiting and out_tready is low.
// Configuration writes through cfg_we/cfg_index/cfg_wdata take effect on the next
// clock and should only be made while no result is outstanding.
`include "debounced_edge_counter_macros.svh"

module debounced_edge_counter (
  input  logic                          clk,
  input  logic                          rst_n,
  // configuration
  input  logic                          cfg_we,
  input  logic [dec_pkg::CfgIdxW-1:0]   cfg_index,
  input  logic [dec_pkg::CfgDataW-1:0]  cfg_wdata,
  // sample stream
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [dec_pkg::InDataW-1:0]   in_tdata,   // raw_level, now_ms[32:1], zero pad
  input  logic [1:0]                    in_tuser,   // opcode
  // result stream
  output logic                          out_tvalid,
  input  logic                          out_tready,
  // stable_level, changed, edge_kind[3:2], change_count[35:4], divided_count[51:36],
  // triggered[52], rise_stamp[84:53], fall_stamp[116:85], change_stamp[148:117],
  // on_duration[180:149], off_duration[212:181], zero pad
  output logic [dec_pkg::OutDataW-1:0]  out_tdata
);

  localparam int unsigned TW = dec_pkg::TimeW;
  localparam int unsigned HW = dec_pkg::HoldW;
  localparam int unsigned DW = dec_pkg::DivW;
  localparam int unsigned CW = dec_pkg::CountW;
  localparam int unsigned PadW = dec_pkg::OutDataW - $bits(dec_pkg::result_t);

  // configuration registers
  logic          deb_en_r;
  logic [HW-1:0] rise_hold_r;
  logic [HW-1:0] fall_hold_r;
  logic [DW-1:0] divide_by_r;
  logic [1:0]    kind_sel_r;

  // block state
  logic          level_r, level_nxt;
  logic          prev_raw_r, prev_raw_nxt;
  logic [1:0]    pending_r, pending_nxt;
  logic [TW-1:0] bounce_r, bounce_nxt;
  logic [CW-1:0] changes_r, changes_nxt;
  logic [DW-1:0] divided_r, divided_nxt;
  logic [TW-1:0] rise_time_r, rise_time_nxt;
  logic [TW-1:0] fall_time_r, fall_time_nxt;
  logic [TW-1:0] change_time_r, change_time_nxt;
  logic          changed_r, changed_nxt;
  logic [1:0]    edge_r, edge_nxt;

  // result register
  logic               out_valid_r;
  dec_pkg::result_t   out_data_r, out_data_nxt;

  // item fields
  dec_pkg::opcode_t op;
  logic             raw;
  logic [TW-1:0]    now;

  logic          in_acc;
  logic [DW-1:0] eff_div;
  logic [HW-1:0] hold;
  logic [TW-1:0] held_for;
  logic          do_commit;
  logic [1:0]    commit_edge;
  logic          kind_match;

  assign op  = dec_pkg::opcode_t'(in_tuser);
  assign raw = in_tdata[0];
  assign now = in_tdata[TW:1];

  // result register frees up whenever its item is taken
  assign in_tready = !out_valid_r || out_tready;
  assign in_acc    = in_tvalid && in_tready;

  // zero divider behaves like one
  assign eff_div = (divide_by_r == '0) ? DW'(1) : divide_by_r;

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      deb_en_r    <= 1'b0;
      rise_hold_r <= dec_pkg::HOLD_RESET;
      fall_hold_r <= dec_pkg::HOLD_RESET;
      divide_by_r <= dec_pkg::DIVIDE_RESET;
      kind_sel_r  <= dec_pkg::EDGE_NONE;
    end else if (cfg_we) begin
      case (cfg_index)
        dec_pkg::CFG_DEBOUNCE_EN: deb_en_r    <= cfg_wdata[0];
        dec_pkg::CFG_RISE_HOLD:   rise_hold_r <= cfg_wdata[HW-1:0];
        dec_pkg::CFG_FALL_HOLD:   fall_hold_r <= cfg_wdata[HW-1:0];
        dec_pkg::CFG_DIVIDE_BY:   divide_by_r <= cfg_wdata[DW-1:0];
        dec_pkg::CFG_EDGE_KIND:   kind_sel_r  <= cfg_wdata[1:0];
        default: begin
        end
      endcase
    end
  end

  // single-pass next state for the item at the input
  always_comb begin
    level_nxt       = level_r;
    prev_raw_nxt    = prev_raw_r;
    pending_nxt     = pending_r;
    bounce_nxt      = bounce_r;
    changes_nxt     = changes_r;
    divided_nxt     = divided_r;
    rise_time_nxt   = rise_time_r;
    fall_time_nxt   = fall_time_r;
    change_time_nxt = change_time_r;
    changed_nxt     = changed_r;
    edge_nxt        = edge_r;
    do_commit       = 1'b0;

    // debounce timing, only meaningful when debounce is on
    if (raw != prev_raw_r) bounce_nxt = now;
    if (raw != level_r) pending_nxt = level_r ? dec_pkg::EDGE_FALL : dec_pkg::EDGE_RISE;
    hold     = (pending_nxt == dec_pkg::EDGE_FALL) ? fall_hold_r : rise_hold_r;
    held_for = now - bounce_nxt;

    commit_edge = raw ? dec_pkg::EDGE_RISE : dec_pkg::EDGE_FALL;
    kind_match  = (kind_sel_r == dec_pkg::EDGE_NONE) || (kind_sel_r == dec_pkg::EDGE_ANY2) ||
                  (kind_sel_r == commit_edge);

    case (op)
      dec_pkg::OP_SAMPLE: begin
        changed_nxt = 1'b0;
        edge_nxt    = dec_pkg::EDGE_NONE;
        if (deb_en_r) begin
          prev_raw_nxt = raw;
          do_commit    = (held_for > TW'(hold)) && (raw != level_r);
        end else begin
          // pass-through leaves the bounce tracking alone
          prev_raw_nxt = prev_raw_r;
          pending_nxt  = pending_r;
          bounce_nxt   = bounce_r;
          do_commit    = (raw != level_r);
        end
        if (do_commit) begin
          changes_nxt     = changes_r + CW'(1);
          edge_nxt        = commit_edge;
          changed_nxt     = 1'b1;
          level_nxt       = raw;
          change_time_nxt = now;
          if (raw) rise_time_nxt = now;
          else     fall_time_nxt = now;
          if (kind_match && (divided_r != dec_pkg::DIV_MAX)) divided_nxt = divided_r + DW'(1);
        end
      end
      dec_pkg::OP_ACK: begin
        pending_nxt = pending_r;
        bounce_nxt  = bounce_r;
        if (divided_r >= eff_div) divided_nxt = '0;
      end
      dec_pkg::OP_CLEAR: begin
        pending_nxt = pending_r;
        bounce_nxt  = bounce_r;
        level_nxt   = 1'b0;
        changes_nxt = '0;
        divided_nxt = '0;
      end
      default: begin
        // no-op command reports the current state
        pending_nxt = pending_r;
        bounce_nxt  = bounce_r;
      end
    endcase

    out_data_nxt.stable_level  = level_nxt;
    out_data_nxt.changed       = changed_nxt;
    out_data_nxt.edge_kind     = edge_nxt;
    out_data_nxt.change_count  = changes_nxt;
    out_data_nxt.divided_count = divided_nxt;
    out_data_nxt.triggered     = (divided_nxt >= eff_div);
    out_data_nxt.rise_stamp    = rise_time_nxt;
    out_data_nxt.fall_stamp    = fall_time_nxt;
    out_data_nxt.change_stamp  = change_time_nxt;
    out_data_nxt.on_duration   = level_nxt ? (now - rise_time_nxt) : '0;
    out_data_nxt.off_duration  = level_nxt ? '0 : (now - fall_time_nxt);
  end

  // state commits only on an accepted item
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      level_r       <= 1'b0;
      prev_raw_r    <= 1'b0;
      pending_r     <= dec_pkg::EDGE_NONE;
      bounce_r      <= '0;
      changes_r     <= '0;
      divided_r     <= '0;
      rise_time_r   <= '0;
      fall_time_r   <= '0;
      change_time_r <= '0;
      changed_r     <= 1'b0;
      edge_r        <= dec_pkg::EDGE_NONE;
    end else if (in_acc) begin
      level_r       <= level_nxt;
      prev_raw_r    <= prev_raw_nxt;
      pending_r     <= pending_nxt;
      bounce_r      <= bounce_nxt;
      changes_r     <= changes_nxt;
      divided_r     <= divided_nxt;
      rise_time_r   <= rise_time_nxt;
      fall_time_r   <= fall_time_nxt;
      change_time_r <= change_time_nxt;
      changed_r     <= changed_nxt;
      edge_r        <= edge_nxt;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_acc) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{PadW{1'b0}}, out_data_r};

  // a reported change always carries a rising or falling edge
  `DEC_ASSERT_NOW(a_changed_has_edge, out_valid_r && out_data_r.changed, out_data_r.edge_kind != dec_pkg::EDGE_NONE, "changed result without an edge")
  // trigger flag tracks the divided count against the effective divider
  `DEC_ASSERT_NOW(a_trigger_consistent, out_valid_r, out_data_r.triggered == (out_data_r.divided_count >= eff_div), "trigger flag disagrees with divided count")
  // a clear item reports zeroed level and counts
  `DEC_ASSERT_NEXT(a_clear_result, in_acc && (op == dec_pkg::OP_CLEAR), out_valid_r && (out_data_r.change_count == '0) && (out_data_r.divided_count == '0) && !out_data_r.stable_level, "clear item did not zero level and counts")
  // any item accepted with debounce off leaves bounce tracking untouched
  `DEC_ASSERT_NEXT(a_bypass_keeps_bounce, in_acc && !deb_en_r, $stable(bounce_r) && $stable(prev_raw_r), "bounce tracking moved with debounce off")

endmodule

/* bench/tb_debounced_edge_counter.sv */
`timescale 1ns / 100ps

module tb_debounced_edge_counter;
  import dec_pkg::*;

  localparam int unsigned PhaseItems = 85;
  localparam int unsigned SatItems   = 24;   // short pass-through toggle burst

  typedef enum {ROW_CFG, ROW_ITEM} row_kind_t;

  // one line of the directed stimulus table
  typedef struct {
    row_kind_t          kind;
    logic [CfgIdxW-1:0] idx;
    logic [15:0]        val;
    opcode_t            op;
    logic               raw;
    logic [31:0]        now;
    bit                 typed;    // use the hand-written result instead of the predictor
    result_t            want;
  } stim_row_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                cfg_we = 1'b0;
  logic [CfgIdxW-1:0]  cfg_index = '0;
  logic [CfgDataW-1:0] cfg_wdata = '0;
  logic                in_tvalid = 1'b0;
  logic                in_tready;
  logic [InDataW-1:0]  in_tdata = '0;
  logic [1:0]          in_tuser = '0;
  logic                out_tvalid;
  logic                out_tready = 1'b0;
  logic [OutDataW-1:0] out_tdata;

  debounced_edge_counter dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always #6 clk = ~clk;

  // shadow copy of the configuration registers, reset values
  logic        sh_debounce = 1'b0;
  logic [15:0] sh_rise_hold = HOLD_RESET;
  logic [15:0] sh_fall_hold = HOLD_RESET;
  logic [15:0] sh_divide = DIVIDE_RESET;
  logic [1:0]  sh_kind = EDGE_NONE;

  // predicted block state
  logic        lvl_q = 1'b0;
  logic        raw_prev_q = 1'b0;
  logic [1:0]  pend_edge_q = EDGE_NONE;   // zero times like a rising edge
  logic [31:0] bounce_t_q = '0;
  logic [31:0] n_changes = '0;
  logic [15:0] n_divided = '0;
  logic [31:0] t_rise = '0;
  logic [31:0] t_fall = '0;
  logic [31:0] t_change = '0;
  logic        chg_flag_q = 1'b0;
  logic [1:0]  edge_q = EDGE_NONE;

  result_t     due_reports[$];   // counter reports still owed by the block
  int          mismatches = 0;
  bit          no_idle = 1'b0;   // both sides run flat out while set
  int          long_hold = 0;    // receiver hold-off request, in cycles

  // a committed level change: stamps, counts and the divided edge count
  function automatic void commit_level(logic lvl, logic [31:0] now);
    n_changes  = n_changes + 32'd1;
    edge_q     = lvl ? EDGE_RISE : EDGE_FALL;
    if (lvl) t_rise = now;
    else t_fall = now;
    t_change   = now;
    lvl_q      = lvl;
    if (sh_kind == EDGE_NONE || sh_kind == EDGE_ANY2 || sh_kind == edge_q) begin
      if (n_divided != DIV_MAX) n_divided = n_divided + 16'd1;
    end
    chg_flag_q = 1'b1;
  endfunction

  // advance the predicted state by one item and build its report
  function automatic result_t next_report(opcode_t op, logic raw, logic [31:0] now);
    result_t     r;
    logic [15:0] div_eff;
    logic [15:0] hold;
    logic [31:0] elapsed;
    div_eff = (sh_divide == 16'd0) ? 16'd1 : sh_divide;
    case (op)
      OP_SAMPLE: begin
        if (!sh_debounce) begin
          // pass-through: bounce tracking stays frozen
          if (raw != lvl_q) commit_level(raw, now);
          else begin
            chg_flag_q = 1'b0;
            edge_q     = EDGE_NONE;
          end
        end else begin
          edge_q     = EDGE_NONE;
          chg_flag_q = 1'b0;
          if (raw != raw_prev_q) bounce_t_q = now;
          if (raw != lvl_q) pend_edge_q = lvl_q ? EDGE_FALL : EDGE_RISE;
          hold    = (pend_edge_q == EDGE_FALL) ? sh_fall_hold : sh_rise_hold;
          elapsed = now - bounce_t_q;
          if (elapsed > {16'd0, hold} && raw != lvl_q) commit_level(raw, now);
          raw_prev_q = raw;
        end
      end
      OP_ACK: begin
        if (n_divided >= div_eff) n_divided = '0;
      end
      OP_CLEAR: begin
        lvl_q     = 1'b0;
        n_changes = '0;
        n_divided = '0;
      end
      default: ;
    endcase
    r.stable_level  = lvl_q;
    r.changed       = chg_flag_q;
    r.edge_kind     = edge_q;
    r.change_count  = n_changes;
    r.divided_count = n_divided;
    r.triggered     = (n_divided >= div_eff);
    r.rise_stamp    = t_rise;
    r.fall_stamp    = t_fall;
    r.change_stamp  = t_change;
    r.on_duration   = lvl_q ? now - t_rise : 32'd0;
    r.off_duration  = lvl_q ? 32'd0 : now - t_fall;
    return r;
  endfunction

  function automatic stim_row_t item_row(opcode_t op, logic raw, logic [31:0] now);
    stim_row_t row;
    row.kind  = ROW_ITEM;
    row.idx   = '0;
    row.val   = '0;
    row.op    = op;
    row.raw   = raw;
    row.now   = now;
    row.typed = 1'b0;
    row.want  = '0;
    return row;
  endfunction

  function automatic stim_row_t cfg_row(logic [CfgIdxW-1:0] idx, logic [15:0] val);
    stim_row_t row;
    row      = item_row(OP_NOP, 1'b0, 32'd0);
    row.kind = ROW_CFG;
    row.idx  = idx;
    row.val  = val;
    return row;
  endfunction

  // drop valid and wait until every owed report is back, plus a short settle
  task automatic wait_drained();
    in_tvalid <= 1'b0;
    wait (due_reports.size() == 0);
    repeat (3) @(posedge clk);
  endtask

  task automatic apply_reg(logic [CfgIdxW-1:0] idx, logic [15:0] val);
    wait_drained();
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we    <= 1'b0;
    case (idx)
      CFG_DEBOUNCE_EN: sh_debounce  = val[0];
      CFG_RISE_HOLD:   sh_rise_hold = val;
      CFG_FALL_HOLD:   sh_fall_hold = val;
      CFG_DIVIDE_BY:   sh_divide    = val;
      CFG_EDGE_KIND:   sh_kind      = val[1:0];
      default: ;
    endcase
  endtask

  // offer one item after a random gap; the report is predicted at acceptance
  task automatic send_item(opcode_t op, logic raw, logic [31:0] now, bit typed,
                           result_t want);
    int      gap;
    result_t rep;
    gap = no_idle ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {{(InDataW-33){1'b0}}, now, raw};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    rep = next_report(op, raw, now);
    due_reports.push_back(typed ? want : rep);
  endtask

  task automatic match_field(string fname, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      mismatches++;
      $display("%0t: %s expected %0h got %0h", $time, fname, want, got);
    end
  endtask

  function automatic logic [15:0] pick_hold();
    case ($urandom_range(0, 7))
      0: return 16'd0;
      1: return 16'hFFFF;
      2: return 16'($urandom_range(0, 65535));
      default: return 16'($urandom_range(0, 40));
    endcase
  endfunction

  function automatic logic [15:0] pick_divider();
    case ($urandom_range(0, 7))
      0: return 16'd0;
      1: return 16'd1;
      2: return 16'hFFFF;
      default: return 16'($urandom_range(1, 5));
    endcase
  endfunction

  // result side: random stalls, one long hold-off on request
  initial begin : result_sink
    int      stall;
    int      n;
    result_t got;
    result_t want;
    wait (rst_n);
    forever begin
      if (long_hold > 0) begin
        n         = long_hold;
        long_hold = 0;
        out_tready <= 1'b0;
        repeat (n) @(posedge clk);
      end else begin
        stall = no_idle ? 0 : $urandom_range(0, 5);
        if (stall > 0) begin
          out_tready <= 1'b0;
          repeat (stall) @(posedge clk);
        end
      end
      out_tready <= 1'b1;
      @(posedge clk);
      while (!out_tvalid) @(posedge clk);
      got = result_t'(out_tdata[$bits(result_t)-1:0]);
      if (due_reports.size() == 0) begin
        mismatches++;
        $display("%0t: result item with none expected, got %0h", $time, got);
      end else begin
        want = due_reports.pop_front();
        match_field("stable_level", 32'(want.stable_level), 32'(got.stable_level));
        match_field("changed", 32'(want.changed), 32'(got.changed));
        match_field("edge_kind", 32'(want.edge_kind), 32'(got.edge_kind));
        match_field("change_count", want.change_count, got.change_count);
        match_field("divided_count", 32'(want.divided_count), 32'(got.divided_count));
        match_field("triggered", 32'(want.triggered), 32'(got.triggered));
        match_field("rise_stamp", want.rise_stamp, got.rise_stamp);
        match_field("fall_stamp", want.fall_stamp, got.fall_stamp);
        match_field("change_stamp", want.change_stamp, got.change_stamp);
        match_field("on_duration", want.on_duration, got.on_duration);
        match_field("off_duration", want.off_duration, got.off_duration);
      end
    end
  end

  // stimulus: directed table, random phases, then a flat-out toggle burst
  initial begin : stimulus
    stim_row_t   plan[$];
    stim_row_t   row;
    opcode_t     op;
    logic        raw;
    logic        target;
    logic [31:0] clock_ms;

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // straight out of reset: nothing committed, nothing counted
    row = item_row(OP_NOP, 1'b0, 32'd0);
    row.typed = 1'b1;
    row.want  = '0;
    plan.push_back(row);
    row = item_row(OP_SAMPLE, 1'b0, 32'd5);
    row.typed = 1'b1;
    row.want  = '{off_duration: 32'd5, default: '0};
    plan.push_back(row);
    // pass-through rise with divide by one fires the trigger at once
    row = item_row(OP_SAMPLE, 1'b1, 32'd100);
    row.typed = 1'b1;
    row.want  = '{stable_level: 1'b1, changed: 1'b1, edge_kind: EDGE_RISE,
                  change_count: 32'd1, divided_count: 16'd1, triggered: 1'b1,
                  rise_stamp: 32'd100, change_stamp: 32'd100, default: '0};
    plan.push_back(row);
    // ack and clear keep reporting the last sample's change flag and edge
    plan.push_back(item_row(OP_ACK, 1'b0, 32'd110));
    plan.push_back(item_row(OP_CLEAR, 1'b1, 32'd120));
    plan.push_back(item_row(OP_NOP, 1'b1, 32'd130));
    // time near the top and across the wrap
    plan.push_back(item_row(OP_SAMPLE, 1'b1, 32'hFFFF_FFF0));
    plan.push_back(item_row(OP_SAMPLE, 1'b0, 32'h0000_0010));
    // kind three counts any change, divider zero acts as one
    plan.push_back(cfg_row(CFG_EDGE_KIND, 16'(EDGE_ANY2)));
    plan.push_back(cfg_row(CFG_DIVIDE_BY, 16'd0));
    plan.push_back(item_row(OP_SAMPLE, 1'b1, 32'hFFFF_FFFF));
    plan.push_back(item_row(OP_ACK, 1'b1, 32'd0));
    // debounce on with the hold extremes
    plan.push_back(cfg_row(CFG_DEBOUNCE_EN, 16'd1));
    plan.push_back(cfg_row(CFG_RISE_HOLD, 16'd0));
    plan.push_back(cfg_row(CFG_FALL_HOLD, 16'hFFFF));
    plan.push_back(cfg_row(CFG_EDGE_KIND, 16'(EDGE_FALL)));
    plan.push_back(cfg_row(CFG_DIVIDE_BY, 16'hFFFF));
    plan.push_back(item_row(OP_SAMPLE, 1'b0, 32'd1000));
    plan.push_back(item_row(OP_SAMPLE, 1'b1, 32'd1001));       // bounce back
    plan.push_back(item_row(OP_SAMPLE, 1'b0, 32'd1002));
    plan.push_back(item_row(OP_SAMPLE, 1'b0, 32'd1002 + 32'd65535));  // hold equal: no commit
    plan.push_back(item_row(OP_SAMPLE, 1'b0, 32'd1002 + 32'd65536));  // one past: fall commits
    plan.push_back(item_row(OP_SAMPLE, 1'b1, 32'h0002_0000));
    plan.push_back(item_row(OP_SAMPLE, 1'b1, 32'h0002_0001));  // rise hold zero: one ms is enough
    plan.push_back(item_row(OP_CLEAR, 1'b0, 32'h0002_0002));
    plan.push_back(item_row(OP_SAMPLE, 1'b1, 32'h0002_0003));  // clear left prev raw high

    foreach (plan[i]) begin
      if (plan[i].kind == ROW_CFG) apply_reg(plan[i].idx, plan[i].val);
      else send_item(plan[i].op, plan[i].raw, plan[i].now, plan[i].typed, plan[i].want);
    end

    // random phases, each under its own configuration
    for (int p = 0; p < 8; p++) begin
      if (p == 0) begin
        apply_reg(CFG_DEBOUNCE_EN, 16'd1);
        apply_reg(CFG_RISE_HOLD, 16'd20);
        apply_reg(CFG_FALL_HOLD, 16'd5);
        apply_reg(CFG_DIVIDE_BY, 16'd3);
        apply_reg(CFG_EDGE_KIND, 16'(EDGE_RISE));
      end else begin
        apply_reg(CFG_DEBOUNCE_EN, 16'($urandom_range(0, 3) != 0));
        apply_reg(CFG_RISE_HOLD, pick_hold());
        apply_reg(CFG_FALL_HOLD, pick_hold());
        apply_reg(CFG_DIVIDE_BY, pick_divider());
        apply_reg(CFG_EDGE_KIND, 16'($urandom_range(0, 3)));
      end
      no_idle  = (p == 3);
      target   = $urandom_range(0, 1);
      clock_ms = $urandom_range(0, 1) ? $urandom() : 32'hFFFF_FF00;
      for (int k = 0; k < PhaseItems; k++) begin
        // receiver holds off while the sender keeps pushing: input must stall
        if (p == 2 && k == 20) begin
          no_idle   = 1'b1;
          long_hold = 60;
        end
        if (p == 2 && k == 40) no_idle = 1'b0;
        // sender pauses until everything is back
        if (p == 5 && k == 40) wait_drained();
        // mostly a pin that bounces then settles, with a sprinkling of commands
        op = ($urandom_range(0, 9) == 0) ? opcode_t'($urandom_range(1, 3)) : OP_SAMPLE;
        if ($urandom_range(0, 7) == 0) target = ~target;
        raw = ($urandom_range(0, 4) == 0) ? ~target : target;
        if ($urandom_range(0, 31) == 0) clock_ms = $urandom();
        else clock_ms = clock_ms + 32'($urandom_range(0, 12));
        send_item(op, raw, clock_ms, 1'b0, '0);
      end
    end

    // pass-through toggling, flat out, every sample commits
    apply_reg(CFG_DEBOUNCE_EN, 16'd0);
    apply_reg(CFG_EDGE_KIND, 16'(EDGE_NONE));
    apply_reg(CFG_DIVIDE_BY, 16'hFFFF);
    no_idle  = 1'b1;
    clock_ms = 32'h8000_0000;
    send_item(OP_CLEAR, 1'b0, clock_ms, 1'b0, '0);
    for (int k = 0; k < SatItems; k++) begin
      clock_ms = clock_ms + 32'd1;
      send_item(OP_SAMPLE, ~lvl_q, clock_ms, 1'b0, '0);
    end
    send_item(OP_ACK, 1'b0, clock_ms, 1'b0, '0);
    send_item(OP_SAMPLE, ~lvl_q, clock_ms + 32'd1, 1'b0, '0);
    no_idle = 1'b0;

    wait_drained();
    repeat (5) @(posedge clk);
    if (mismatches == 0) begin
      $display("** debounced_edge_counter: PASSED **");
    end else begin
      $display("** debounced_edge_counter: FAILED **");
    end
    $finish;
  end

  // watchdog, far beyond the slowest legal run
  initial begin : watchdog
    #12_000_000;
    $display("** debounced_edge_counter: FAILED **");
    $finish;
  end

endmodule
